// File: hw/rtl/subset_c_lexer_top_macros.svh
// Assertion macros for the lexer port checker.
`ifndef SUBSET_C_LEXER_TOP_MACROS_SVH
`define SUBSET_C_LEXER_TOP_MACROS_SVH

// Same-cycle implication.
`define SLEX_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lexer port check failed");

// Next-cycle implication.
`define SLEX_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lexer port check failed");

`endif

// File: hw/rtl/slex_pkg.sv
// Shared types, token codes and character classes for the lexer.
package slex_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_NAME,
    MODE_OP
  } mode_t;

  typedef enum logic [2:0] {
    OUT_PEND,
    OUT_COMBO,
    OUT_CHAR,
    OUT_NAME,
    OUT_END
  } out_sel_t;

  typedef struct packed {
    logic     capture;
    logic     acc;
    logic     append;
    logic     lex;
    logic     clear;
    logic     rd;
    logic     chunk_inc;
    logic     load;
    out_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  in_eoi;
    logic  in_digit;
    logic  in_namechar;
    logic  in_eq;
    logic  lat_eoi;
    logic  lat_single;
    logic  name_done;
    logic  out_free;
  } dp_stat_t;

  localparam logic signed [9:0] TK_END    = -10'sd1;
  localparam logic signed [9:0] TK_NAME   = 10'sd257;
  localparam logic signed [9:0] TK_NUMBER = 10'sd258;
  localparam logic signed [9:0] TK_WHILE  = 10'sd259;
  localparam logic signed [9:0] TK_IF     = 10'sd260;
  localparam logic signed [9:0] TK_PRINT  = 10'sd261;
  localparam logic signed [9:0] TK_EQ     = 10'sd262;
  localparam logic signed [9:0] TK_NE     = 10'sd263;
  localparam logic signed [9:0] TK_LE     = 10'sd264;
  localparam logic signed [9:0] TK_GE     = 10'sd265;
  localparam logic signed [9:0] TK_ELSE   = 10'sd266;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Keywords packed first character in the low byte.
  localparam logic [63:0] KW_WHILE = 64'h0000_0065_6C69_6877;
  localparam logic [63:0] KW_IF    = 64'h0000_0000_0000_6669;
  localparam logic [63:0] KW_ELSE  = 64'h0000_0000_6573_6C65;
  localparam logic [63:0] KW_PRINT = 64'h0000_0074_6E69_7270;

  localparam logic [5:0] KW_WHILE_LEN = 6'd5;
  localparam logic [5:0] KW_IF_LEN    = 6'd2;
  localparam logic [5:0] KW_ELSE_LEN  = 6'd4;
  localparam logic [5:0] KW_PRINT_LEN = 6'd5;

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return b inside {8'h20, 8'h0A, 8'h09, 8'h0D};
  endfunction

  function automatic logic is_opch(input logic [7:0] b);
    return b inside {CH_EQ, CH_BANG, CH_LT, CH_GT};
  endfunction

endpackage

// File: hw/rtl/subset_c_lexer_top.sv
// A single word is loaded from the held byte in the lex state; each name chunk is read from
// the name store, then emitted; an end word follows a flushed token. A digit in a number or
// a character in a name is taken in idle; any other byte or end mark from idle goes through
// the lex or end state, '=' completing an operator through combo; one ending a number or
// operator flushes it, one ending a name emits its 8-character chunks; a held word stalls.
// Reset (synchronous) clears mode, counters and output valid; the name store is not cleared.
module subset_c_lexer_top #(
  parameter int NAME_MAX = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              end_of_input,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [9:0] token_kind,
  output logic [31:0]       number_value,
  output logic [5:0]        name_length,
  output logic [2:0]        chunk_index,
  output logic [63:0]       name_chunk,
  output logic              last
);

  slex_pkg::dp_cmd_t  cmd;
  slex_pkg::dp_stat_t stat;

  slex_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slex_dp #(
    .NAME_MAX (NAME_MAX)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .token_kind   (token_kind),
    .number_value (number_value),
    .name_length  (name_length),
    .chunk_index  (chunk_index),
    .name_chunk   (name_chunk),
    .last         (last)
  );

endmodule

// File: hw/rtl/slex_ctrl.sv
// Lexer controller: sequences accept, flush, name chunk runs and end words.
module slex_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  slex_pkg::dp_stat_t stat,
  output slex_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLUSH,
    S_COMBO,
    S_NAME_RD,
    S_NAME_EMIT,
    S_LEX,
    S_END
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.sel    = slex_pkg::OUT_PEND;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (stat.in_eoi) begin
            case (stat.mode)
              slex_pkg::MODE_NAME:                    state_next = S_NAME_RD;
              slex_pkg::MODE_NUM, slex_pkg::MODE_OP:  state_next = S_FLUSH;
              default:                                state_next = S_END;
            endcase
          end else if (stat.mode == slex_pkg::MODE_NUM && stat.in_digit) begin
            cmd.acc = 1'b1;
          end else if (stat.mode == slex_pkg::MODE_NAME && stat.in_namechar) begin
            cmd.append = 1'b1;
          end else if (stat.mode == slex_pkg::MODE_OP && stat.in_eq) begin
            state_next = S_COMBO;
          end else begin
            case (stat.mode)
              slex_pkg::MODE_NAME:                    state_next = S_NAME_RD;
              slex_pkg::MODE_NUM, slex_pkg::MODE_OP:  state_next = S_FLUSH;
              default:                                state_next = S_LEX;
            endcase
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = slex_pkg::OUT_PEND;
          cmd.clear  = 1'b1;
          state_next = stat.lat_eoi ? S_END : S_LEX;
        end
      end
      S_COMBO: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = slex_pkg::OUT_COMBO;
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_NAME_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_NAME_EMIT;
      end
      S_NAME_EMIT: begin
        if (stat.out_free) begin
          cmd.load = 1'b1;
          cmd.sel  = slex_pkg::OUT_NAME;
          if (stat.name_done) begin
            cmd.clear  = 1'b1;
            state_next = stat.lat_eoi ? S_END : S_LEX;
          end else begin
            cmd.chunk_inc = 1'b1;
            state_next    = S_NAME_RD;
          end
        end
      end
      S_LEX: begin
        if (stat.lat_single) begin
          if (stat.out_free) begin
            cmd.load   = 1'b1;
            cmd.sel    = slex_pkg::OUT_CHAR;
            cmd.lex    = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.lex    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = slex_pkg::OUT_END;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/slex_dp.sv
// Lexer datapath: accumulator, name store, pending operator and output word register.
module slex_dp #(
  parameter int NAME_MAX = 63
) (
  input  logic               clk,
  input  logic               rst,
  input  slex_pkg::dp_cmd_t  cmd,
  output slex_pkg::dp_stat_t stat,
  input  logic [7:0]         in_byte,
  input  logic               end_of_input,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [9:0]  token_kind,
  output logic [31:0]        number_value,
  output logic [5:0]         name_length,
  output logic [2:0]         chunk_index,
  output logic [63:0]        name_chunk,
  output logic               last
);

  localparam int ROWS  = (NAME_MAX + 7) / 8;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  slex_pkg::mode_t mode;
  logic [31:0]     acc;
  logic [5:0]      cnt;
  logic [7:0]      pend;
  logic [7:0]      lat_byte;
  logic            lat_eoi;
  logic [2:0]      chunk;
  logic [63:0]     rd_data;
  logic [63:0]     mem [ROWS];

  logic            wr_en;
  logic [7:0]      wr_byte;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] rd_row;
  logic            room;
  logic [63:0]     masked;
  logic            is_kw;
  logic signed [9:0] kw_kind;
  logic            last_chunk;
  logic signed [9:0] combo_kind;
  logic [31:0]     digit_in;
  logic [31:0]     digit_lat;

  logic signed [9:0] token_kind_next;
  logic [31:0]     number_value_next;
  logic [5:0]      name_length_next;
  logic [2:0]      chunk_index_next;
  logic [63:0]     name_chunk_next;
  logic            last_next;

  assign room      = cnt < 6'(NAME_MAX);
  assign wr_en     = (cmd.append && room) || (cmd.lex && slex_pkg::is_alpha(lat_byte));
  assign wr_byte   = cmd.lex ? lat_byte : in_byte;
  assign wr_row    = ROW_W'(cnt >> 3);
  assign rd_row    = ROW_W'(chunk);
  assign digit_in  = {24'd0, in_byte - slex_pkg::CH_ZERO};
  assign digit_lat = {24'd0, lat_byte - slex_pkg::CH_ZERO};

  // Name store: one 64-bit row per chunk, byte lanes written as characters arrive.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][8*cnt[2:0] +: 8] <= wr_byte;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_row];
    end
  end

  // Lanes at or beyond the kept length read as zero.
  always_comb begin
    logic [5:0] lane_pos;
    masked = '0;
    for (int i = 0; i < 8; i++) begin
      lane_pos = {chunk, 3'(i)};
      if (lane_pos < cnt) begin
        masked[8*i +: 8] = rd_data[8*i +: 8];
      end
    end
  end

  always_comb begin
    is_kw   = 1'b0;
    kw_kind = slex_pkg::TK_NAME;
    if (chunk == 3'd0) begin
      if (cnt == slex_pkg::KW_WHILE_LEN && masked == slex_pkg::KW_WHILE) begin
        is_kw   = 1'b1;
        kw_kind = slex_pkg::TK_WHILE;
      end else if (cnt == slex_pkg::KW_IF_LEN && masked == slex_pkg::KW_IF) begin
        is_kw   = 1'b1;
        kw_kind = slex_pkg::TK_IF;
      end else if (cnt == slex_pkg::KW_ELSE_LEN && masked == slex_pkg::KW_ELSE) begin
        is_kw   = 1'b1;
        kw_kind = slex_pkg::TK_ELSE;
      end else if (cnt == slex_pkg::KW_PRINT_LEN && masked == slex_pkg::KW_PRINT) begin
        is_kw   = 1'b1;
        kw_kind = slex_pkg::TK_PRINT;
      end
    end
  end

  assign last_chunk = (chunk == 3'((cnt - 6'd1) >> 3));

  always_comb begin
    case (pend)
      slex_pkg::CH_BANG: combo_kind = slex_pkg::TK_NE;
      slex_pkg::CH_LT:   combo_kind = slex_pkg::TK_LE;
      slex_pkg::CH_GT:   combo_kind = slex_pkg::TK_GE;
      default:           combo_kind = slex_pkg::TK_EQ;
    endcase
  end

  always_comb begin
    token_kind_next   = slex_pkg::TK_END;
    number_value_next = '0;
    name_length_next  = '0;
    chunk_index_next  = '0;
    name_chunk_next   = '0;
    last_next         = 1'b1;
    case (cmd.sel)
      slex_pkg::OUT_PEND: begin
        if (mode == slex_pkg::MODE_NUM) begin
          token_kind_next   = slex_pkg::TK_NUMBER;
          number_value_next = acc;
        end else begin
          token_kind_next = 10'({2'b00, pend});
        end
      end
      slex_pkg::OUT_COMBO: token_kind_next = combo_kind;
      slex_pkg::OUT_CHAR:  token_kind_next = 10'({2'b00, lat_byte});
      slex_pkg::OUT_NAME: begin
        if (is_kw) begin
          token_kind_next = kw_kind;
        end else begin
          token_kind_next  = slex_pkg::TK_NAME;
          name_length_next = cnt;
          chunk_index_next = chunk;
          name_chunk_next  = masked;
          last_next        = last_chunk;
        end
      end
      default: token_kind_next = slex_pkg::TK_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      token_kind   <= token_kind_next;
      number_value <= number_value_next;
      name_length  <= name_length_next;
      chunk_index  <= chunk_index_next;
      name_chunk   <= name_chunk_next;
      last         <= last_next;
    end
    if (cmd.capture) begin
      lat_byte <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= slex_pkg::MODE_IDLE;
      acc       <= '0;
      cnt       <= '0;
      pend      <= '0;
      chunk     <= '0;
      lat_eoi   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        lat_eoi <= end_of_input;
      end
      if (cmd.acc) begin
        acc <= (acc << 3) + (acc << 1) + digit_in;
      end
      if (cmd.append && room) begin
        cnt <= cnt + 6'd1;
      end
      if (cmd.chunk_inc) begin
        chunk <= chunk + 3'd1;
      end
      if (cmd.clear) begin
        mode  <= slex_pkg::MODE_IDLE;
        acc   <= '0;
        cnt   <= '0;
        pend  <= '0;
        chunk <= '0;
      end
      // Start a new token from the held byte; whitespace and single words leave idle.
      if (cmd.lex) begin
        if (slex_pkg::is_digit(lat_byte)) begin
          mode <= slex_pkg::MODE_NUM;
          acc  <= digit_lat;
        end else if (slex_pkg::is_alpha(lat_byte)) begin
          mode <= slex_pkg::MODE_NAME;
          cnt  <= 6'd1;
        end else if (slex_pkg::is_opch(lat_byte)) begin
          mode <= slex_pkg::MODE_OP;
          pend <= lat_byte;
        end
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.mode        = mode;
    stat.in_eoi      = end_of_input;
    stat.in_digit    = slex_pkg::is_digit(in_byte);
    stat.in_namechar = slex_pkg::is_alpha(in_byte) || slex_pkg::is_digit(in_byte) ||
                       (in_byte == slex_pkg::CH_US);
    stat.in_eq       = (in_byte == slex_pkg::CH_EQ);
    stat.lat_eoi     = lat_eoi;
    stat.lat_single  = !(slex_pkg::is_ws(lat_byte) || slex_pkg::is_digit(lat_byte) ||
                         slex_pkg::is_alpha(lat_byte) || slex_pkg::is_opch(lat_byte));
    stat.name_done   = is_kw || last_chunk;
    stat.out_free    = !out_valid || out_ready;
  end

endmodule

// File: hw/rtl/slex_checker.sv
// Port-level checker for the lexer, bound to the top level.
`include "subset_c_lexer_top_macros.svh"

module slex_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [9:0] token_kind,
  input logic [31:0]       number_value,
  input logic [5:0]        name_length,
  input logic [2:0]        chunk_index,
  input logic [63:0]       name_chunk,
  input logic              last
);

  logic [115:0] out_word;
  logic         out_held;
  logic         name_word;
  logic         num_word;
  logic         no_name_fields;
  logic [2:0]   final_idx;
  logic         idx_ok;
  logic         last_ok;

  assign out_word       = {token_kind, number_value, name_length, chunk_index, name_chunk, last};
  assign out_held       = out_valid && !out_ready;
  assign name_word      = out_valid && (token_kind == slex_pkg::TK_NAME);
  assign num_word       = out_valid && (token_kind == slex_pkg::TK_NUMBER);
  assign no_name_fields = (name_length == 6'd0) && (chunk_index == 3'd0) && (name_chunk == 64'd0);
  assign final_idx      = 3'((name_length - 6'd1) >> 3);
  assign idx_ok         = (name_length != 6'd0) && (chunk_index <= final_idx);
  assign last_ok        = (last == (chunk_index == final_idx));

  // A stalled word holds.
  `SLEX_ASSERT_NEXT(a_out_hold, clk, rst, out_held, out_valid && $stable(out_word))

  // Only name words carry name fields or runs.
  `SLEX_ASSERT_NOW(a_single_word, clk, rst, out_valid && !name_word, last && no_name_fields)

  // Only number words carry a value.
  `SLEX_ASSERT_NOW(a_number_only, clk, rst, out_valid && !num_word, number_value == 32'd0)

  // A name chunk lies within its length, and the last one is the final chunk.
  `SLEX_ASSERT_NOW(a_name_chunk, clk, rst, name_word, idx_ok && last_ok)

endmodule

bind subset_c_lexer_top slex_checker u_slex_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .token_kind   (token_kind),
  .number_value (number_value),
  .name_length  (name_length),
  .chunk_index  (chunk_index),
  .name_chunk   (name_chunk),
  .last         (last)
);
